>>> hdl/vvbs_pkg.sv
// Package: word sizes and fixed-point constants for the body step pipeline.
`default_nettype none
package vvbs_pkg;
  localparam int unsigned WORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam logic [31:0] TIME_STEP_RESET = 32'd65536;
endpackage
`default_nettype wire

>>> hdl/velocity_verlet_body_step.sv
// Top level: pipelined velocity-Verlet half step for one body per request.
//
//  channel | ports                   | handshake
//  in      | in_kind .. in_body_mass | in_valid / in_ready
//  out     | out_new_pos_x .. skipped| out_valid / out_ready
//  cfg     | cfg_time_step           | cfg_we, no wait
//
// One request per cycle while the output is not stalled; the pipe is the
// bit-per-stage divider followed by an accel saturation stage, two multiply
// stages and two add stages.
// The whole pipe advances when the last stage is empty or taken; a stall
// freezes every stage. Reset clears valid bits and sets time_step to 1.0.
`default_nettype none
module velocity_verlet_body_step #(
  parameter int unsigned WORD_WIDTH = vvbs_pkg::WORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = vvbs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic        [WORD_WIDTH-1:0] cfg_time_step,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_kind,
  input  wire logic signed [WORD_WIDTH-1:0] in_pos_x,
  input  wire logic signed [WORD_WIDTH-1:0] in_pos_y,
  input  wire logic signed [WORD_WIDTH-1:0] in_pos_z,
  input  wire logic signed [WORD_WIDTH-1:0] in_vel_x,
  input  wire logic signed [WORD_WIDTH-1:0] in_vel_y,
  input  wire logic signed [WORD_WIDTH-1:0] in_vel_z,
  input  wire logic signed [WORD_WIDTH-1:0] in_force_x,
  input  wire logic signed [WORD_WIDTH-1:0] in_force_y,
  input  wire logic signed [WORD_WIDTH-1:0] in_force_z,
  input  wire logic        [WORD_WIDTH-1:0] in_body_mass,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed      [WORD_WIDTH-1:0] out_new_pos_x,
  output logic signed      [WORD_WIDTH-1:0] out_new_pos_y,
  output logic signed      [WORD_WIDTH-1:0] out_new_pos_z,
  output logic signed      [WORD_WIDTH-1:0] out_new_vel_x,
  output logic signed      [WORD_WIDTH-1:0] out_new_vel_y,
  output logic signed      [WORD_WIDTH-1:0] out_new_vel_z,
  output logic                              out_clear_force,
  output logic                              out_skipped
);
  localparam int unsigned W   = WORD_WIDTH;
  localparam int unsigned NW  = WORD_WIDTH + FRAC_BITS;
  localparam int unsigned DL  = NW;            // divider stages
  localparam int unsigned NS  = DL + 5;        // total stages
  localparam int unsigned PW  = 2 * W + 2;     // product width

  typedef struct packed {
    logic                kind;
    logic                skip;
    logic [2:0][W-1:0]   pos;
    logic [2:0][W-1:0]   vel;
    logic [2:0]          fneg;
  } side_t;

  logic [W-1:0] time_step_r;
  logic         adv;
  logic [NS-1:0] v_r;
  side_t        side_r [NS];
  side_t        side_in;

  always_ff @(posedge clk) begin
    if (!rst_n) time_step_r <= W'(vvbs_pkg::TIME_STEP_RESET);
    else if (cfg_we) time_step_r <= cfg_time_step;
  end

  assign adv      = !v_r[NS-1] || out_ready;
  assign in_ready = adv;

  logic signed [W-1:0] f_in [3];
  assign f_in[0] = in_force_x;
  assign f_in[1] = in_force_y;
  assign f_in[2] = in_force_z;

  always_comb begin
    side_in.kind = in_kind;
    side_in.skip = (in_body_mass == '0);
    side_in.pos  = {in_pos_z, in_pos_y, in_pos_x};
    side_in.vel  = {in_vel_z, in_vel_y, in_vel_x};
    side_in.fneg = {in_force_z[W-1], in_force_y[W-1], in_force_x[W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int s = 1; s < NS; s++) side_r[s] <= side_r[s-1];
    end
  end

  // Per-axis datapath: divider (stages 1..DL), accel sat, dv mult, v add,
  // dp mult, p add.
  logic [W-1:0] np_o [3];
  logic [W-1:0] nv_o [3];
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [W-1:0]  mag;
    logic [NW-1:0] num;
    logic [NW-1:0] quo;
    logic signed [W-1:0] acc_r;
    logic signed [PW-1:0] dv_r;
    logic signed [W-1:0]  nv_r;
    logic signed [PW-1:0] dp_r;
    logic signed [W-1:0]  nv2_r;
    logic signed [W-1:0]  nv3_r;
    logic signed [W-1:0]  np_r;
    logic signed [W-1:0]  acc_nxt;
    logic signed [PW-1:0] dv_nxt;
    logic signed [PW-1:0] vs;
    logic signed [W-1:0]  nv_nxt;
    logic signed [PW-1:0] dp_nxt;
    logic signed [PW-1:0] ps;
    logic signed [W-1:0]  np_nxt;
    side_t sa, sc, sd, se;

    assign mag = f_in[a][W-1] ? (~f_in[a] + 1'b1) : f_in[a];
    assign num = {mag, {FRAC_BITS{1'b0}}};

    vvbs_div #(.NUM_W(NW), .DEN_W(W)) u_div (
      .clk(clk), .en(adv), .num(num), .den(in_body_mass), .quo(quo)
    );

    assign sa = side_r[DL-1];
    assign sc = side_r[DL+1];
    assign sd = side_r[DL+3];

    always_comb begin
      if (sa.fneg[a]) begin
        if (quo > NW'({1'b1, {(W-1){1'b0}}})) acc_nxt = SMIN;
        else acc_nxt = W'(~quo + 1'b1);
      end else begin
        if (quo > NW'(SMAX)) acc_nxt = SMAX;
        else acc_nxt = W'(quo);
      end
      dv_nxt = PW'(acc_r) * $signed({2'b00, time_step_r});
      vs = PW'($signed(sc.vel[a])) + (dv_r >>> (FRAC_BITS + 1));
      if (vs > PW'(SMAX)) nv_nxt = SMAX;
      else if (vs < PW'(SMIN)) nv_nxt = SMIN;
      else nv_nxt = W'(vs);
      dp_nxt = PW'(nv_r) * $signed({2'b00, time_step_r});
      ps = PW'($signed(sd.pos[a])) + (dp_r >>> FRAC_BITS);
      if (ps > PW'(SMAX)) np_nxt = SMAX;
      else if (ps < PW'(SMIN)) np_nxt = SMIN;
      else np_nxt = W'(ps);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        acc_r <= acc_nxt;
        dv_r  <= dv_nxt;
        nv_r  <= nv_nxt;
        dp_r  <= dp_nxt;
        nv2_r <= nv_r;
        nv3_r <= nv2_r;
        if (sd.skip) begin
          np_r <= sd.pos[a];
        end else if (sd.kind) begin
          np_r <= sd.pos[a];
        end else begin
          np_r <= np_nxt;
        end
      end
    end

    assign se   = side_r[NS-1];
    assign np_o[a] = np_r;
    assign nv_o[a] = se.skip ? se.vel[a] : nv3_r;
  end

  side_t so;
  assign so = side_r[NS-1];
  assign out_valid       = v_r[NS-1];
  assign out_new_pos_x   = np_o[0];
  assign out_new_pos_y   = np_o[1];
  assign out_new_pos_z   = np_o[2];
  assign out_new_vel_x   = nv_o[0];
  assign out_new_vel_y   = nv_o[1];
  assign out_new_vel_z   = nv_o[2];
  assign out_clear_force = !so.kind && !so.skip;
  assign out_skipped     = so.skip;
endmodule
`default_nettype wire

>>> hdl/vvbs_div.sv
// Pipelined restoring divider, one quotient bit per stage, magnitude in and out.
`default_nettype none
module vvbs_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo
);
  logic [NUM_W-1:0] q_r   [NUM_W+1];
  logic [DEN_W:0]   rem_r [NUM_W+1];
  logic [DEN_W-1:0] d_r   [NUM_W+1];

  assign q_r[0]   = num;
  assign rem_r[0] = '0;
  assign d_r[0]   = den;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W+1:0] sh;
    logic [DEN_W+1:0] df;
    logic [NUM_W-1:0] qs_r;
    logic [DEN_W:0]   rs_r;
    logic [DEN_W-1:0] ds_r;
    assign sh = {rem_r[s], q_r[s][NUM_W-1]};
    assign df = sh - {2'b00, d_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        ds_r <= d_r[s];
        if (!df[DEN_W+1]) begin
          rs_r <= df[DEN_W:0];
          qs_r <= {q_r[s][NUM_W-2:0], 1'b1};
        end else begin
          rs_r <= sh[DEN_W:0];
          qs_r <= {q_r[s][NUM_W-2:0], 1'b0};
        end
      end
    end
    assign q_r[s+1]   = qs_r;
    assign rem_r[s+1] = rs_r;
    assign d_r[s+1]   = ds_r;
  end
  assign quo = q_r[NUM_W];
endmodule
`default_nettype wire
